// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the correlation block RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset
`define AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/pcorr_pkg.sv =====
// Package: types, widths and codes for the Pearson correlation block.
`timescale 1ns / 1ps
package pcorr_pkg;

    localparam int MAX_SAMPLES_DEF  = 1024;
    localparam int MAX_FEATURES_DEF = 4096;
    localparam int SAMPLE_BITS_DEF  = 16;

    localparam int CNT_W  = 11;
    localparam int SX_W   = 26;
    localparam int SXX_W  = 41;
    localparam int SXY_W  = 42;
    localparam int WIDE_W = 136;
    localparam int THR_W  = 15;

    typedef struct packed {
        logic signed [15:0] x_sample;
        logic signed [15:0] y_sample;
        logic [11:0]        first_feature;
        logic [11:0]        second_feature;
        logic               last_sample;
    } in_item_t;

    typedef struct packed {
        logic [12:0]        from_feature;
        logic [12:0]        to_feature;
        logic signed [15:0] correlation_weight;
    } out_item_t;

    // One closed feature pair handed from front to back
    typedef struct packed {
        logic signed [SX_W-1:0]  sx;
        logic signed [SX_W-1:0]  sy;
        logic [SXX_W-1:0]        sxx;
        logic [SXX_W-1:0]        syy;
        logic signed [SXY_W-1:0] sxy;
        logic [CNT_W-1:0]        n;
        logic [12:0]             from_feature;
        logic [12:0]             to_feature;
        logic                    feat_ok;
    } pair_job_t;

    typedef enum logic [2:0] {
        OP_NSXY, OP_SXSY, OP_NSXX, OP_SXSX, OP_NSYY, OP_SYSY, OP_NUM2, OP_VXVY
    } mul_op_t;

    typedef enum logic [2:0] {
        BK_IDLE, BK_LOAD, BK_MUL, BK_CHECK, BK_SRCH_A, BK_SRCH_B, BK_OUT
    } bk_state_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

// ===== rtl/pcorr_front.sv =====
// Front end: takes sample transactions, accumulates sums, closes pairs.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pcorr_front #(
    parameter int MAX_SAMPLES  = pcorr_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_FEATURES = pcorr_pkg::MAX_FEATURES_DEF,
    parameter int SAMPLE_BITS  = pcorr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  pcorr_pkg::in_item_t  in_data,
    input  logic                 q_full,
    output logic                 push,
    output pcorr_pkg::pair_job_t job
);

    logic signed [pcorr_pkg::SX_W-1:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [pcorr_pkg::SXX_W-1:0]        sxx_reg, sxx_next, syy_reg, syy_next;
    logic signed [pcorr_pkg::SXY_W-1:0] sxy_reg, sxy_next;
    logic [pcorr_pkg::CNT_W-1:0]        count_reg, count_next;
    logic signed [SAMPLE_BITS-1:0]      xn, yn;
    logic signed [15:0]                 xs, ys;
    logic signed [31:0]                 xx, yy, xy;
    logic                               accept, take;

    assign accept = in_valid && !q_full;
    assign push   = accept && in_data.last_sample;

    // sign extend from the low sample bits
    assign xn = in_data.x_sample[SAMPLE_BITS-1:0];
    assign yn = in_data.y_sample[SAMPLE_BITS-1:0];
    assign xs = 16'(xn);
    assign ys = 16'(yn);
    assign xx = xs * xs;
    assign yy = ys * ys;
    assign xy = xs * ys;

    assign take = count_reg < pcorr_pkg::CNT_W'(MAX_SAMPLES);

    // sums including this transaction while the sample count is below MAX_SAMPLES
    always_comb
    begin
        sx_next    = sx_reg;
        sy_next    = sy_reg;
        sxx_next   = sxx_reg;
        syy_next   = syy_reg;
        sxy_next   = sxy_reg;
        count_next = count_reg;
        if (take)
        begin
            sx_next    = sx_reg + pcorr_pkg::SX_W'(xs);
            sy_next    = sy_reg + pcorr_pkg::SX_W'(ys);
            sxx_next   = sxx_reg + pcorr_pkg::SXX_W'(xx);
            syy_next   = syy_reg + pcorr_pkg::SXX_W'(yy);
            sxy_next   = sxy_reg + pcorr_pkg::SXY_W'(xy);
            count_next = count_reg + 1'b1;
        end
    end

    // job for the back end
    always_comb
    begin
        job.sx           = sx_next;
        job.sy           = sy_next;
        job.sxx          = sxx_next;
        job.syy          = syy_next;
        job.sxy          = sxy_next;
        job.n            = count_next;
        job.from_feature = 13'(in_data.first_feature) + 13'd1;
        job.to_feature   = 13'(in_data.second_feature) + 13'd1;
        job.feat_ok      = ({1'b0, in_data.first_feature} < 13'(MAX_FEATURES))
                        && ({1'b0, in_data.second_feature} < 13'(MAX_FEATURES));
    end

    // accumulators, cleared when a pair closes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            count_reg <= '0;
        end
        else if (push)
        begin
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            syy_reg   <= '0;
            sxy_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            sx_reg    <= sx_next;
            sy_reg    <= sy_next;
            sxx_reg   <= sxx_next;
            syy_reg   <= syy_next;
            sxy_reg   <= sxy_next;
            count_reg <= count_next;
        end
    end

    `AST_IMP(a_cnt_bound, 1'b1, count_reg <= pcorr_pkg::CNT_W'(MAX_SAMPLES))
    `AST_NXT(a_clear_after_push, push, count_reg == '0)

endmodule

// ===== rtl/pcorr_queue.sv =====
// Two-entry queue of closed pairs between front and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pcorr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  pcorr_pkg::pair_job_t push_job,
    input  logic                 pop,
    output logic                 full,
    output logic                 not_empty,
    output pcorr_pkg::pair_job_t head
);

    pcorr_pkg::pair_job_t slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full      = fill_reg == 2'd2;
    assign not_empty = fill_reg != 2'd0;
    assign head      = slot_reg[rd_ptr_reg];

    // payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    `AST_IMP(a_no_overflow, full, !push)
    `AST_IMP(a_no_underflow, !not_empty, !pop)

endmodule

// ===== rtl/pcorr_back.sv =====
// Back end: serial multiplies, variance check and bitwise search for r.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pcorr_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_not_empty,
    input  pcorr_pkg::pair_job_t              q_head,
    output logic                              pop,
    input  logic [pcorr_pkg::THR_W-1:0]       threshold,
    output logic                              out_valid,
    input  logic                              out_stall,
    output pcorr_pkg::out_item_t              out_data
);

    localparam int W = pcorr_pkg::WIDE_W;

    pcorr_pkg::bk_state_t state_reg, state_next;
    pcorr_pkg::mul_op_t   op_reg, op_next;
    pcorr_pkg::pair_job_t job_reg, job_next;
    pcorr_pkg::out_item_t out_reg, out_next;
    logic [127:0]        acc_reg, acc_next, ma_reg, ma_next, prod;
    logic [63:0]         mb_reg, mb_next, a_sel, b_sel;
    logic                neg_reg, neg_next, neg_sel;
    logic signed [63:0]  t1_reg, t1_next, num_reg, num_next;
    logic signed [63:0]  vx_reg, vx_next, vy_reg, vy_next, p64;
    logic [W-1:0]        l_reg, l_next, v_reg, v_next, p_reg, p_next;
    logic [W-1:0]        qv_reg, qv_next, s_reg, s_next, t_val;
    logic [14:0]         q_reg, q_next;
    logic [3:0]          bit_reg, bit_next;

    assign out_valid = state_reg == pcorr_pkg::BK_OUT;
    assign out_data  = out_reg;
    assign pop       = (state_reg == pcorr_pkg::BK_IDLE) && q_not_empty;

    assign prod = neg_reg ? 128'(-acc_reg) : acc_reg;
    assign p64  = prod[63:0];

    // multiplier operands (magnitudes) and product sign per step
    always_comb
    begin
        a_sel   = 64'(job_reg.n);
        b_sel   = '0;
        neg_sel = 1'b0;
        case (op_reg)
            pcorr_pkg::OP_NSXY:
            begin
                b_sel   = pcorr_pkg::mag64(64'(job_reg.sxy));
                neg_sel = job_reg.sxy[pcorr_pkg::SXY_W-1];
            end
            pcorr_pkg::OP_SXSY:
            begin
                a_sel   = pcorr_pkg::mag64(64'(job_reg.sx));
                b_sel   = pcorr_pkg::mag64(64'(job_reg.sy));
                neg_sel = job_reg.sx[pcorr_pkg::SX_W-1] ^ job_reg.sy[pcorr_pkg::SX_W-1];
            end
            pcorr_pkg::OP_NSXX: b_sel = 64'(job_reg.sxx);
            pcorr_pkg::OP_SXSX:
            begin
                a_sel = pcorr_pkg::mag64(64'(job_reg.sx));
                b_sel = a_sel;
            end
            pcorr_pkg::OP_NSYY: b_sel = 64'(job_reg.syy);
            pcorr_pkg::OP_SYSY:
            begin
                a_sel = pcorr_pkg::mag64(64'(job_reg.sy));
                b_sel = a_sel;
            end
            pcorr_pkg::OP_NUM2:
            begin
                a_sel = pcorr_pkg::mag64(num_reg);
                b_sel = a_sel;
            end
            pcorr_pkg::OP_VXVY:
            begin
                a_sel = 64'(vx_reg);
                b_sel = 64'(vy_reg);
            end
            default: b_sel = '0;
        endcase
    end

    // trial value for the current result bit
    assign t_val = s_reg + (qv_reg << (5'(bit_reg) + 5'd1));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        job_next   = job_reg;
        out_next   = out_reg;
        acc_next   = acc_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        neg_next   = neg_reg;
        t1_next    = t1_reg;
        num_next   = num_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        l_next     = l_reg;
        v_next     = v_reg;
        p_next     = p_reg;
        qv_next    = qv_reg;
        s_next     = s_reg;
        q_next     = q_reg;
        bit_next   = bit_reg;
        case (state_reg)
            pcorr_pkg::BK_IDLE:
            begin
                if (q_not_empty)
                begin
                    job_next   = q_head;
                    op_next    = pcorr_pkg::OP_NSXY;
                    state_next = pcorr_pkg::BK_LOAD;
                end
            end
            pcorr_pkg::BK_LOAD:
            begin
                acc_next   = '0;
                ma_next    = 128'(a_sel);
                mb_next    = b_sel;
                neg_next   = neg_sel;
                state_next = pcorr_pkg::BK_MUL;
            end
            pcorr_pkg::BK_MUL:
            begin
                if (mb_reg != '0)
                begin
                    // shift-add, one multiplier bit a cycle
                    if (mb_reg[0])
                    begin
                        acc_next = acc_reg + ma_reg;
                    end
                    ma_next = ma_reg << 1;
                    mb_next = mb_reg >> 1;
                end
                else
                begin
                    op_next    = pcorr_pkg::mul_op_t'(op_reg + 3'd1);
                    state_next = pcorr_pkg::BK_LOAD;
                    case (op_reg)
                        pcorr_pkg::OP_NSXY: t1_next = p64;
                        pcorr_pkg::OP_SXSY: num_next = t1_reg - p64;
                        pcorr_pkg::OP_NSXX: t1_next = p64;
                        pcorr_pkg::OP_SXSX: vx_next = t1_reg - p64;
                        pcorr_pkg::OP_NSYY: t1_next = p64;
                        pcorr_pkg::OP_SYSY:
                        begin
                            vy_next    = t1_reg - p64;
                            state_next = pcorr_pkg::BK_CHECK;
                        end
                        pcorr_pkg::OP_NUM2: l_next = W'(acc_reg) << 30;
                        pcorr_pkg::OP_VXVY:
                        begin
                            v_next     = W'(acc_reg);
                            p_next     = '0;
                            qv_next    = '0;
                            q_next     = '0;
                            bit_next   = 4'd14;
                            state_next = pcorr_pkg::BK_SRCH_A;
                        end
                        default: state_next = pcorr_pkg::BK_IDLE;
                    endcase
                end
            end
            pcorr_pkg::BK_CHECK:
            begin
                // zero variance or bad feature index: drop the pair
                if ((vx_reg <= 0) || (vy_reg <= 0) || !job_reg.feat_ok)
                begin
                    state_next = pcorr_pkg::BK_IDLE;
                end
                else
                begin
                    op_next    = pcorr_pkg::OP_NUM2;
                    state_next = pcorr_pkg::BK_LOAD;
                end
            end
            pcorr_pkg::BK_SRCH_A:
            begin
                s_next     = p_reg + (v_reg << {bit_reg, 1'b0});
                state_next = pcorr_pkg::BK_SRCH_B;
            end
            pcorr_pkg::BK_SRCH_B:
            begin
                // keep bit if (q+2^b)^2*V <= num^2*2^30
                if (t_val <= l_reg)
                begin
                    p_next          = t_val;
                    qv_next         = qv_reg + (v_reg << bit_reg);
                    q_next[bit_reg] = 1'b1;
                end
                if (bit_reg == 4'd0)
                begin
                    if (q_next > threshold)
                    begin
                        out_next.from_feature       = job_reg.from_feature;
                        out_next.to_feature         = job_reg.to_feature;
                        out_next.correlation_weight = num_reg[63]
                            ? 16'(-{1'b0, q_next}) : 16'({1'b0, q_next});
                        state_next = pcorr_pkg::BK_OUT;
                    end
                    else
                    begin
                        state_next = pcorr_pkg::BK_IDLE;
                    end
                end
                else
                begin
                    bit_next   = bit_reg - 4'd1;
                    state_next = pcorr_pkg::BK_SRCH_A;
                end
            end
            pcorr_pkg::BK_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = pcorr_pkg::BK_IDLE;
                end
            end
            default: state_next = pcorr_pkg::BK_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pcorr_pkg::BK_IDLE;
            op_reg    <= pcorr_pkg::OP_NSXY;
            bit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            bit_reg   <= bit_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
        acc_reg <= acc_next;
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        t1_reg  <= t1_next;
        num_reg <= num_next;
        vx_reg  <= vx_next;
        vy_reg  <= vy_next;
        l_reg   <= l_next;
        v_reg   <= v_next;
        p_reg   <= p_next;
        qv_reg  <= qv_next;
        s_reg   <= s_next;
        q_reg   <= q_next;
    end

    `AST_IMP(a_pop_only_idle, pop, state_reg == pcorr_pkg::BK_IDLE)
    `AST_NXT(a_search_end, (state_reg == pcorr_pkg::BK_SRCH_B) && (bit_reg == 4'd0),
             (state_reg == pcorr_pkg::BK_OUT) || (state_reg == pcorr_pkg::BK_IDLE))

endmodule

// ===== rtl/pearson_correlation_threshold.sv =====
// Top level: Pearson correlation edge detector with APB threshold register.
// Flow: a pair closes on its last sample; the edge follows after 8 serial
//   multiplies, each with its load step, a check and a bitwise search.
// Throughput: one sample per cycle while the two-entry pair queue has room;
//   pairs are finished one at a time by the shared shift-add multiplier.
// Reset: sums, counts and queue clear; threshold resets to 0.
`timescale 1ns / 1ps
module pearson_correlation_threshold #(
    parameter int MAX_SAMPLES  = pcorr_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_FEATURES = pcorr_pkg::MAX_FEATURES_DEF,
    parameter int SAMPLE_BITS  = pcorr_pkg::SAMPLE_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  pcorr_pkg::in_item_t in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output pcorr_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [pcorr_pkg::THR_W-1:0] thr_reg;
    logic                        push, pop, q_full, q_not_empty;
    pcorr_pkg::pair_job_t        push_job, head;

    // configuration register
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? 32'd0 : 32'(thr_reg);
    assign in_stall = q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (psel && penable && pwrite && !paddr[2])
        begin
            thr_reg <= pwdata[pcorr_pkg::THR_W-1:0];
        end
    end

    pcorr_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_FEATURES(MAX_FEATURES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_data (in_data),
        .q_full  (q_full),
        .push    (push),
        .job     (push_job)
    );

    pcorr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .full     (q_full),
        .not_empty(q_not_empty),
        .head     (head)
    );

    pcorr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_not_empty(q_not_empty),
        .q_head     (head),
        .pop        (pop),
        .threshold  (thr_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ===== tb/pearson_correlation_threshold_tb.sv =====
// Testbench for the Pearson correlation edge detector: random and directed pairs, scored.
`timescale 1ns / 1ps
module pearson_correlation_threshold_tb;

    localparam int PAIR_SAMPLES = 1024;
    localparam int FEATURES     = 4096;
    localparam int DRAIN_CYCLES = 2000;
    localparam logic [2:0] THRESH_ADDR = 3'd0;

    // Pair modes for the stimulus
    typedef enum int {
        PM_RANDOM, PM_SAME, PM_NEGATED, PM_FLAT, PM_NOISY, PM_EXTREME
    } pair_mode_t;

    // Edge predictor plus queue of pending edges
    class edge_scoreboard;
        longint sum_x, sum_y, sum_xx, sum_yy, sum_xy;
        int     count;
        int     threshold;
        int     errors;
        pcorr_pkg::out_item_t pending_edges[$];

        function new();
            clear_sums();
            threshold = 0;
            errors = 0;
        endfunction

        function void clear_sums();
            sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
            count = 0;
        endfunction

        // Accumulate one accepted transaction; on the last mark predict the edge
        function void note_sample(pcorr_pkg::in_item_t it);
            longint x, y, n, num, vx, vy;
            logic [63:0]  anum;
            logic [159:0] lhs, vxy, rhs;
            logic [31:0]  q, c;
            pcorr_pkg::out_item_t e;
            x = longint'(it.x_sample);
            y = longint'(it.y_sample);
            if (count < PAIR_SAMPLES)
            begin
                sum_x += x; sum_y += y;
                sum_xx += x * x; sum_yy += y * y; sum_xy += x * y;
                count++;
            end
            if (!it.last_sample)
                return;
            n   = longint'(count);
            num = n * sum_xy - sum_x * sum_y;
            vx  = n * sum_xx - sum_x * sum_x;
            vy  = n * sum_yy - sum_y * sum_y;
            clear_sums();
            if (vx <= 0 || vy <= 0)
                return;
            if (int'(it.first_feature) >= FEATURES || int'(it.second_feature) >= FEATURES)
                return;
            // largest q below 2^15 with q^2 * vx * vy <= num^2 * 2^30
            anum = (num < 0) ? 64'(-num) : 64'(num);
            lhs  = (160'(anum) * 160'(anum)) << 30;
            vxy  = 160'(64'(vx)) * 160'(64'(vy));
            q = 0;
            for (int b = 14; b >= 0; b--)
            begin
                c   = q | (32'd1 << b);
                rhs = vxy * 160'(c * c);
                if (rhs <= lhs)
                    q = c;
            end
            if (int'(q) <= threshold)
                return;
            e.from_feature       = 13'(it.first_feature) + 13'd1;
            e.to_feature         = 13'(it.second_feature) + 13'd1;
            e.correlation_weight = (num < 0) ? -16'(q) : 16'(q);
            pending_edges.insert(pending_edges.size(), e);
        endfunction

        // Compare an accepted edge with the oldest prediction
        function void check_edge(pcorr_pkg::out_item_t got);
            pcorr_pkg::out_item_t want;
            if (pending_edges.size() == 0)
            begin
                $error("unexpected edge from=%0d to=%0d weight=%0d",
                       got.from_feature, got.to_feature, got.correlation_weight);
                errors++;
                return;
            end
            want = pending_edges.pop_front();
            if (got.from_feature !== want.from_feature)
            begin
                $error("from_feature expected %0d actual %0d",
                       want.from_feature, got.from_feature);
                errors++;
            end
            if (got.to_feature !== want.to_feature)
            begin
                $error("to_feature expected %0d actual %0d", want.to_feature, got.to_feature);
                errors++;
            end
            if (got.correlation_weight !== want.correlation_weight)
            begin
                $error("correlation_weight expected %0d actual %0d",
                       want.correlation_weight, got.correlation_weight);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    pcorr_pkg::in_item_t  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    pcorr_pkg::out_item_t out_data;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    edge_scoreboard sb = new();
    bit quiet = 1'b0;
    int samples_sent = 0;

    pearson_correlation_threshold dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Drive one sample transaction after a random gap
    task automatic push_sample(pcorr_pkg::in_item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  = it;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_sample(it);
        samples_sent++;
        @(negedge clk);
    endtask

    // Send one feature pair of n samples
    task automatic send_pair(int n, pair_mode_t mode, logic [11:0] f1, logic [11:0] f2);
        pcorr_pkg::in_item_t it;
        logic signed [15:0] flat;
        flat = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            it.first_feature  = f1;
            it.second_feature = f2;
            it.last_sample    = (i == n - 1);
            it.x_sample       = 16'($urandom);
            it.y_sample       = 16'($urandom);
            case (mode)
                PM_SAME:    it.y_sample = it.x_sample;
                PM_NEGATED: it.y_sample = -it.x_sample;
                PM_FLAT:    it.x_sample = flat;
                PM_NOISY:   it.y_sample = it.x_sample + 16'($urandom_range(0, 2047)) - 16'sd1024;
                PM_EXTREME:
                begin
                    it.x_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                    it.y_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
                end
                default: ;
            endcase
            push_sample(it);
        end
        in_valid = 1'b0;
    endtask

    // Let the block drain, then write the threshold over APB
    task automatic set_threshold(int value);
        in_valid = 1'b0;
        wait (sb.pending_edges.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = THRESH_ADDR;
        pwdata  = 32'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.threshold = value & 32'h7fff;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Receiver: random stall before each edge, check on acceptance
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = quiet ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
            sb.check_edge(out_data);
        end
    end

    // Main stimulus
    initial
    begin
        int thr_list[6];
        int n;
        pair_mode_t m;
        thr_list = '{32767, 16384, 0, 30000, 1000, 0};
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed pairs at the reset threshold of zero
        send_pair(2, PM_SAME, 12'hfff, 12'hfff);
        send_pair(3, PM_NEGATED, 12'h000, 12'hfff);
        send_pair(1, PM_RANDOM, 12'h001, 12'h002);
        send_pair(3, PM_FLAT, 12'h003, 12'h004);
        send_pair(4, PM_EXTREME, 12'h800, 12'h7ff);
        send_pair(4, PM_RANDOM, 12'h005, 12'h005);
        send_pair(4, PM_NOISY, 12'hffe, 12'h000);

        // Random phases, one threshold each
        for (int ph = 0; ph < 6; ph++)
        begin
            set_threshold(ph == 5 ? $urandom_range(0, 32767) : thr_list[ph]);
            quiet = (ph == 2);
            if (ph == 3)
                send_pair(1030, PM_NOISY, 12'($urandom), 12'($urandom));
            while (samples_sent < 25 + 125 * (ph + 1) + (ph >= 3 ? 1030 : 0))
            begin
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(1, 8);
                m = pair_mode_t'($urandom_range(0, 5));
                send_pair(n, m, 12'($urandom), 12'($urandom));
            end
            quiet = 1'b0;
        end

        in_valid = 1'b0;
        wait (sb.pending_edges.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.pending_edges.size() == 0)
            $display("pearson_correlation_threshold test passed");
        else
            $display("pearson_correlation_threshold test failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40ms;
        $display("pearson_correlation_threshold test failed");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/pcorr_pkg.sv
rtl/pcorr_front.sv
rtl/pcorr_queue.sv
rtl/pcorr_back.sv
rtl/pearson_correlation_threshold.sv
tb/pearson_correlation_threshold_tb.sv
